[src/fqrs_pkg.sv]
package fqrs_pkg;

  localparam int SIZE_BITS = 24;
  localparam int Q_W = 7;
  localparam int TARGET_W = 16;
  localparam int STEP_W = 3;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam int IN_FIELDS_W = SIZE_BITS + Q_W + 1;
  localparam int IN_DATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((Q_W + 7) / 8) * 8;

  // 10*size against 9*1024*target and 11*1024*target
  localparam int RATE_W = TARGET_W + 10;
  localparam int CMP_W = (SIZE_BITS + 4 > RATE_W + 4) ? SIZE_BITS + 4 : RATE_W + 4;

  localparam logic [Q_W-1:0] MAX_Q_RESET = Q_W'(90);
  localparam logic [Q_W-1:0] MIN_Q_RESET = Q_W'(30);
  localparam logic [STEP_W-1:0] STEP_START = STEP_W'(4);

  typedef logic [CMP_W-1:0] cmp_t;
  typedef logic signed [Q_W+1:0] qwork_t;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_TRIAL = 1'b1
  } kind_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_TARGET_KB   = 2'd0,
    CFG_MAX_QUALITY = 2'd1,
    CFG_MIN_QUALITY = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    kind_t                kind;
    logic [SIZE_BITS-1:0] compressed_size;
    logic [Q_W-1:0]       quality_used;
    logic                 retried;
  } item_t;

  typedef struct packed {
    logic [Q_W-1:0] quality;
    logic           done_res;
  } result_t;

endpackage

[src/fqrs_in_stage.sv]
module fqrs_in_stage (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [fqrs_pkg::IN_DATA_W-1:0] s_axis_tdata,
  input  logic                           s_axis_tuser,
  input  logic                           advance,
  output logic                           item_valid,
  output fqrs_pkg::item_t                item
);

  logic accept;

  assign s_axis_tready = !item_valid || advance;
  assign accept = s_axis_tvalid && s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (accept) begin
      item_valid <= 1'b1;
    end else if (advance) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.kind <= fqrs_pkg::kind_t'(s_axis_tuser);
      item.compressed_size <= s_axis_tdata[fqrs_pkg::SIZE_BITS-1:0];
      item.quality_used <=
        s_axis_tdata[fqrs_pkg::SIZE_BITS+fqrs_pkg::Q_W-1:fqrs_pkg::SIZE_BITS];
      item.retried <= s_axis_tdata[fqrs_pkg::SIZE_BITS+fqrs_pkg::Q_W];
    end
  end

endmodule

[src/fqrs_core.sv]
module fqrs_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fqrs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fqrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            advance,
  input  fqrs_pkg::item_t                 item,
  output fqrs_pkg::result_t               result,
  output logic [fqrs_pkg::STEP_W-1:0]     step_size
);

  logic [fqrs_pkg::TARGET_W-1:0] target_kb;
  logic [fqrs_pkg::Q_W-1:0]      max_quality;
  logic [fqrs_pkg::Q_W-1:0]      min_quality;

  logic [fqrs_pkg::Q_W-1:0]    carried_quality, carried_quality_next;
  logic [fqrs_pkg::Q_W-1:0]    requested_quality, requested_quality_next;
  logic [fqrs_pkg::STEP_W-1:0] step_size_next;
  logic                        seen_up, seen_up_next;
  logic                        seen_down, seen_down_next;

  logic [fqrs_pkg::RATE_W-1:0] rate;
  fqrs_pkg::cmp_t              s10, r9, r11;
  logic                        below_band, above_band, under_high, below_rate;
  fqrs_pkg::qwork_t            q, q_max, q_min, q_clamp, nudge;
  logic                        stop;

  assign rate = {target_kb, 10'b0};
  assign s10 = fqrs_pkg::cmp_t'(item.compressed_size) * fqrs_pkg::cmp_t'(10);
  assign r9 = fqrs_pkg::cmp_t'(rate) * fqrs_pkg::cmp_t'(9);
  assign r11 = fqrs_pkg::cmp_t'(rate) * fqrs_pkg::cmp_t'(11);
  assign below_band = s10 < r9;
  assign above_band = s10 > r11;
  assign under_high = s10 < r11;
  assign below_rate = fqrs_pkg::cmp_t'(item.compressed_size) < fqrs_pkg::cmp_t'(rate);
  assign q_max = {2'b00, max_quality};
  assign q_min = {2'b00, min_quality};

  always_comb begin
    carried_quality_next = carried_quality;
    requested_quality_next = requested_quality;
    step_size_next = step_size;
    seen_up_next = seen_up;
    seen_down_next = seen_down;
    stop = 1'b0;
    q = {2'b00, item.quality_used};
    q_clamp = '0;
    nudge = '0;
    result.quality = max_quality;
    result.done_res = 1'b1;

    if (target_kb == '0) begin
      if (item.kind == fqrs_pkg::KIND_START) begin
        carried_quality_next = max_quality;
      end
    end else if (item.kind == fqrs_pkg::KIND_START) begin
      q_clamp = {2'b00, carried_quality};
      if (q_clamp > q_max) q_clamp = q_max;
      if (q_clamp < q_min) q_clamp = q_min;
      carried_quality_next = q_clamp[fqrs_pkg::Q_W-1:0];
      requested_quality_next = q_clamp[fqrs_pkg::Q_W-1:0];
      seen_up_next = 1'b0;
      seen_down_next = 1'b0;
      step_size_next = fqrs_pkg::STEP_START;
      result.quality = q_clamp[fqrs_pkg::Q_W-1:0];
      result.done_res = 1'b0;
    end else begin
      if (below_band) begin
        if (item.retried) begin
          q = {2'b00, requested_quality};
          stop = 1'b1;
        end else if (q == q_max) begin
          stop = 1'b1;
        end else begin
          seen_up_next = 1'b1;
          if (seen_down) step_size_next = step_size >> 1;
          q = q + {6'b0, step_size_next};
        end
      end else if (above_band) begin
        if (q == q_min) begin
          stop = 1'b1;
        end else begin
          seen_down_next = 1'b1;
          if (seen_up) step_size_next = step_size >> 1;
          q = q - {6'b0, step_size_next};
        end
      end else begin
        stop = 1'b1;
      end

      if (!stop && step_size_next == '0) begin
        if (under_high) stop = 1'b1;
        else q = q - 9'sd1;
      end

      if (stop) begin
        nudge = below_rate ? q + 9'sd1 : q - 9'sd1;
        if (nudge < 9'sd0) nudge = 9'sd0;
        if (nudge > 9'sd127) nudge = 9'sd127;
        carried_quality_next = nudge[fqrs_pkg::Q_W-1:0];
        result.quality = q[fqrs_pkg::Q_W-1:0];
        result.done_res = 1'b1;
      end else begin
        q_clamp = q;
        if (q_clamp > q_max) q_clamp = q_max;
        if (q_clamp < q_min) q_clamp = q_min;
        carried_quality_next = q_clamp[fqrs_pkg::Q_W-1:0];
        requested_quality_next = q_clamp[fqrs_pkg::Q_W-1:0];
        result.quality = q_clamp[fqrs_pkg::Q_W-1:0];
        result.done_res = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_kb <= '0;
      max_quality <= fqrs_pkg::MAX_Q_RESET;
      min_quality <= fqrs_pkg::MIN_Q_RESET;
    end else if (cfg_we) begin
      case (fqrs_pkg::cfg_idx_t'(cfg_addr))
        fqrs_pkg::CFG_TARGET_KB:   target_kb <= cfg_wdata[fqrs_pkg::TARGET_W-1:0];
        fqrs_pkg::CFG_MAX_QUALITY: max_quality <= cfg_wdata[fqrs_pkg::Q_W-1:0];
        fqrs_pkg::CFG_MIN_QUALITY: min_quality <= cfg_wdata[fqrs_pkg::Q_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      carried_quality <= fqrs_pkg::MAX_Q_RESET;
      requested_quality <= '0;
      step_size <= fqrs_pkg::STEP_START;
      seen_up <= 1'b0;
      seen_down <= 1'b0;
    end else if (advance) begin
      carried_quality <= carried_quality_next;
      requested_quality <= requested_quality_next;
      step_size <= step_size_next;
      seen_up <= seen_up_next;
      seen_down <= seen_down_next;
    end
  end

endmodule

[src/fqrs_out_stage.sv]
module fqrs_out_stage (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  fqrs_pkg::result_t               result,
  output logic                            space,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [fqrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  output logic                            m_axis_tlast
);

  logic [fqrs_pkg::Q_W-1:0] quality;

  assign space = !m_axis_tvalid || m_axis_tready;
  assign m_axis_tdata = fqrs_pkg::OUT_DATA_W'(quality);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      quality <= result.quality;
      m_axis_tlast <= result.done_res;
    end
  end

endmodule

[src/frame_quality_rate_search_top.sv]
// Per-frame quality search toward a target compressed size (plus or minus 10 percent).
// A start word (tuser 0) clamps the carried quality into [min_quality, max_quality]
// and returns it as the first trial; each trial-result word (tuser 1) returns the
// next trial quality, or the final quality with tlast high. With target_kb zero
// every word returns max_quality as final. One result word per input word; a word
// is accepted every cycle unless the output register is stalled, and its result is
// held in the output register (the input register feeds a state update into the
// result register). The search state for one word is ready for the next word in
// the following cycle.
// Write the configuration registers only while no word is in flight.
module frame_quality_rate_search_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [fqrs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [fqrs_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // compressed_size, quality_used, retried
  input  logic [fqrs_pkg::IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // quality
  output logic [fqrs_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // done_res
  output logic                            m_axis_tlast
);

  fqrs_pkg::item_t             item;
  fqrs_pkg::result_t           result;
  logic                        item_valid;
  logic                        space;
  logic                        advance;
  logic [fqrs_pkg::STEP_W-1:0] step_size;

  assign advance = item_valid && space;

  fqrs_in_stage u_in (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .advance      (advance),
    .item_valid   (item_valid),
    .item         (item)
  );

  fqrs_core u_core (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_wdata(cfg_wdata),
    .advance  (advance),
    .item     (item),
    .result   (result),
    .step_size(step_size)
  );

  fqrs_out_stage u_out (
    .clk          (clk),
    .rst          (rst),
    .advance      (advance),
    .result       (result),
    .space        (space),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  a_step_power: assert property (@(posedge clk) disable iff (rst)
    $onehot0(step_size))
    else $error("step size is not a power of two or zero");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid && !item_valid)
    else $error("pipeline not empty after reset");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    item_valid && m_axis_tvalid && !m_axis_tready |=> item_valid)
    else $error("input word lost while output stalled");

  a_ready_when_free: assert property (@(posedge clk) disable iff (rst)
    !item_valid |-> s_axis_tready)
    else $error("input not ready with empty input register");
`endif

endmodule

[verif/quality_search_checker.sv]
module quality_search_checker
  import fqrs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  s_axis_tvalid,
  input  logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  input  logic                  s_axis_tuser,
  input  logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  m_axis_tlast,
  output int                    fail_count,
  output int                    outstanding
);

  logic [TARGET_W-1:0] target_kb;
  logic [Q_W-1:0]      max_q;
  logic [Q_W-1:0]      min_q;
  logic [Q_W-1:0]      carried_q;
  logic [Q_W-1:0]      requested_q;
  logic [STEP_W-1:0]   step;
  logic                seen_up;
  logic                seen_down;

  result_t quality_expect_q[$];

  initial begin
    fail_count = 0;
    outstanding = 0;
  end

  function automatic int clamp_quality(input int q);
    int c;
    c = q;
    if (c > int'(max_q)) c = int'(max_q);
    if (c < int'(min_q)) c = int'(min_q);
    return c;
  endfunction

  task automatic predict_quality(input item_t it, output result_t res);
    longint unsigned rate;
    longint unsigned s10;
    int              q;
    int              nudged;
    logic            stop;
    rate = 64'(target_kb) * 64'd1024;
    s10 = 64'(it.compressed_size) * 64'd10;
    q = int'(it.quality_used);
    stop = 1'b0;
    if (target_kb == '0) begin
      // search disabled: fixed maximum quality, final at once
      if (it.kind == KIND_START) carried_q = max_q;
      res.quality = max_q;
      res.done_res = 1'b1;
    end else if (it.kind == KIND_START) begin
      carried_q = Q_W'(clamp_quality(int'(carried_q)));
      requested_q = carried_q;
      seen_up = 1'b0;
      seen_down = 1'b0;
      step = STEP_START;
      res.quality = carried_q;
      res.done_res = 1'b0;
    end else begin
      if (s10 < 64'd9 * rate) begin
        if (it.retried) begin
          q = int'(requested_q);
          stop = 1'b1;
        end else if (q == int'(max_q)) begin
          stop = 1'b1;
        end else begin
          seen_up = 1'b1;
          if (seen_down) step = step >> 1;
          q = q + int'(step);
        end
      end else if (s10 > 64'd11 * rate) begin
        if (q == int'(min_q)) begin
          stop = 1'b1;
        end else begin
          seen_down = 1'b1;
          if (seen_up) step = step >> 1;
          q = q - int'(step);
        end
      end else begin
        stop = 1'b1;
      end
      if (!stop && step == '0) begin
        if (s10 < 64'd11 * rate) stop = 1'b1;
        else q = q - 1;
      end
      if (stop) begin
        res.quality = Q_W'(q);
        res.done_res = 1'b1;
        nudged = (64'(it.compressed_size) < rate) ? q + 1 : q - 1;
        if (nudged < 0) nudged = 0;
        if (nudged > 127) nudged = 127;
        carried_q = Q_W'(nudged);
      end else begin
        carried_q = Q_W'(clamp_quality(q));
        requested_q = carried_q;
        res.quality = carried_q;
        res.done_res = 1'b0;
      end
    end
  endtask

  always @(posedge clk) begin
    item_t   it;
    result_t want;
    result_t got;
    if (rst) begin
      target_kb = '0;
      max_q = MAX_Q_RESET;
      min_q = MIN_Q_RESET;
      carried_q = MAX_Q_RESET;
      requested_q = '0;
      step = STEP_START;
      seen_up = 1'b0;
      seen_down = 1'b0;
      quality_expect_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_TARGET_KB:   target_kb = cfg_wdata[TARGET_W-1:0];
          CFG_MAX_QUALITY: max_q = cfg_wdata[Q_W-1:0];
          CFG_MIN_QUALITY: min_q = cfg_wdata[Q_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.quality = m_axis_tdata[Q_W-1:0];
        got.done_res = m_axis_tlast;
        if (quality_expect_q.size() == 0) begin
          $display("%0t: unexpected word quality %0d done %0b", $time, got.quality,
                   got.done_res);
          fail_count++;
        end else begin
          want = quality_expect_q.pop_front();
          if (got.quality !== want.quality) begin
            $display("%0t: quality mismatch expected %0d actual %0d", $time, want.quality,
                     got.quality);
            fail_count++;
          end
          if (got.done_res !== want.done_res) begin
            $display("%0t: done mismatch expected %0b actual %0b", $time, want.done_res,
                     got.done_res);
            fail_count++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        it.kind = kind_t'(s_axis_tuser);
        it.compressed_size = s_axis_tdata[SIZE_BITS-1:0];
        it.quality_used = s_axis_tdata[SIZE_BITS+Q_W-1:SIZE_BITS];
        it.retried = s_axis_tdata[SIZE_BITS+Q_W];
        predict_quality(it, want);
        quality_expect_q.push_back(want);
      end
    end
    outstanding = quality_expect_q.size();
  end

endmodule

[verif/frame_quality_rate_search_top_tb.sv]
module frame_quality_rate_search_top_tb;
  import fqrs_pkg::*;

  localparam int WORD_COUNT = 1450;
  localparam int CALM_AFTER = 1300;
  localparam int CYCLE_LIMIT = 500000;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  int   fail_count;
  int   outstanding;
  int   words_sent = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic [Q_W-1:0]      last_q = '0;
  logic                last_done = 1'b0;
  logic [TARGET_W-1:0] cur_target = '0;

  frame_quality_rate_search_top DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  quality_search_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .fail_count    (fail_count),
    .outstanding   (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // latest quality handed back, used as the next compressor setting
  always @(posedge clk) begin
    if (m_axis_tvalid && m_axis_tready) begin
      last_q <= m_axis_tdata[Q_W-1:0];
      last_done <= m_axis_tlast;
    end
  end

  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_word(input kind_t kind, input logic [SIZE_BITS-1:0] size,
                           input logic [Q_W-1:0] q, input logic retried);
    @(negedge clk);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= kind;
    s_axis_tdata <= IN_DATA_W'({retried, q, size});
    do @(posedge clk); while (!s_axis_tready);
    words_sent++;
    if (words_sent >= CALM_AFTER) calm = 1'b1;
  endtask

  task automatic settle();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  task automatic wait_idle();
    settle();
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_limits(input logic [TARGET_W-1:0] target, input int max_q,
                             input int min_q);
    wait_idle();
    write_reg(CFG_TARGET_KB, CFG_DATA_W'(target));
    write_reg(CFG_MAX_QUALITY, CFG_DATA_W'(max_q));
    write_reg(CFG_MIN_QUALITY, CFG_DATA_W'(min_q));
    cur_target = target;
  endtask

  task automatic send_noise();
    send_word(kind_t'($urandom_range(0, 1)), SIZE_BITS'($urandom),
              Q_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
  endtask

  // compressor stand-in: size grows linearly with quality around a per-frame sweet spot
  task automatic run_frame();
    int               sweet_q;
    int               trials;
    longint unsigned  size;
    logic [Q_W-1:0]   q_used;
    logic             retried;
    sweet_q = $urandom_range(1, 100);
    trials = 0;
    send_word(KIND_START, SIZE_BITS'($urandom), Q_W'($urandom), 1'($urandom));
    settle();
    while (!last_done && trials < 14 && words_sent < WORD_COUNT) begin
      q_used = last_q;
      retried = 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        retried = 1'b1;
        q_used = (q_used > 10) ? q_used - Q_W'($urandom_range(0, 10)) : q_used;
      end
      size = 64'(cur_target) * 64'd1024 * 64'(q_used) * 64'($urandom_range(95, 105))
             / 64'(sweet_q * 100);
      if ($urandom_range(0, 7) == 0) size = 64'($urandom_range(0, 24'hFFFFFF));
      if (size > 64'h00FF_FFFF) size = 64'h00FF_FFFF;
      send_word(KIND_TRIAL, SIZE_BITS'(size), q_used, retried);
      settle();
      trials++;
    end
  endtask

  initial begin
    int next_reload;
    int target;
    int max_q;
    int min_q;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // trial straight after reset, then start, both with the search disabled
    send_word(KIND_TRIAL, '0, '0, 1'b0);
    send_word(KIND_START, 24'hFFFFFF, 7'd127, 1'b1);

    load_limits(16'd100, 90, 30);
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd90, 1'b0);
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd90, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd86, 1'b0);
    send_word(KIND_TRIAL, 24'd200000, 7'd88, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd87, 1'b0);
    // step runs out on a downward move
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd60, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd56, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd58, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd59, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd50, 1'b1);
    send_word(KIND_TRIAL, 24'd102400, 7'd60, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd30, 1'b0);

    // nudge saturation at both ends of the field
    load_limits(16'd100, 100, 1);
    send_word(KIND_TRIAL, 24'd100000, 7'd127, 1'b0);
    send_word(KIND_TRIAL, 24'd110000, 7'd0, 1'b0);
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, '0, 7'd0, 1'b0);

    // min above max
    load_limits(16'd100, 1, 100);
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd5, 1'b0);

    load_limits(16'd65535, 100, 1);
    send_word(KIND_START, '0, '0, 1'b0);
    send_word(KIND_TRIAL, 24'hFFFFFF, 7'd100, 1'b0);

    load_limits(16'd1, 100, 1);
    send_word(KIND_TRIAL, 24'h5A5A5A, 7'd64, 1'b1);

    next_reload = words_sent;
    while (words_sent < WORD_COUNT) begin
      if (words_sent >= next_reload) begin
        case ($urandom_range(0, 9))
          0:       target = 0;
          1:       target = 65535;
          2:       target = 1;
          default: target = $urandom_range(1, 16000);
        endcase
        max_q = ($urandom_range(0, 5) == 0) ? 100 : $urandom_range(1, 100);
        min_q = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 100) : $urandom_range(1, max_q);
        load_limits(TARGET_W'(target), max_q, min_q);
        next_reload = words_sent + $urandom_range(100, 200);
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 4)) send_noise();
      end else begin
        run_frame();
      end
    end

    settle();
    repeat (10) @(negedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
